[sv/lbp_pkg.sv]
// Shared types and constants for the 3x3 local binary pattern operator.
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int OUT_ROW_W      = 12;
    localparam int OUT_COL_W      = 10;
    localparam int SIZE_RESET     = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIX_W-1:0]     pixel_t;
    typedef logic [OUT_ROW_W-1:0] out_row_t;
    typedef logic [OUT_COL_W-1:0] out_col_t;

    // one column of the window, index 0 is the top row
    typedef logic [2:0][PIX_W-1:0] lbp_column_t;

    typedef struct packed {
        pixel_t pixel_value;
        logic   frame_start;
    } pixel_in_t;

    typedef struct packed {
        pixel_t   code_value;
        out_row_t out_row;
        out_col_t out_column;
        logic     is_border;
        logic     last_of_run;
    } lbp_result_t;

    // results caused by one pixel: LBP code first, border copy second
    typedef struct packed {
        logic        code_valid;
        logic        border_valid;
        lbp_result_t code_res;
        lbp_result_t border_res;
    } lbp_pair_t;

endpackage

`default_nettype wire

[sv/lbp_line_store.sv]
// Upper and middle line stores with registered read and same-address forwarding.
`timescale 1ns / 1ps
`default_nettype none

module lbp_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire lbp_pkg::pixel_t      wr_upper,
    input  wire lbp_pkg::pixel_t      wr_middle,
    output lbp_pkg::pixel_t           rd_upper,
    output lbp_pkg::pixel_t           rd_middle
);

    lbp_pkg::pixel_t mem_upper [DEPTH];
    lbp_pkg::pixel_t mem_middle [DEPTH];
    lbp_pkg::pixel_t rd_upper_reg;
    lbp_pkg::pixel_t rd_middle_reg;
    logic            fwd_hit;

    assign fwd_hit = wr_en && (rd_addr == wr_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_upper[wr_addr]  <= wr_upper;
            mem_middle[wr_addr] <= wr_middle;
        end
    end

    // write and read in the same cycle at one address: take the new data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (fwd_hit) begin
                rd_upper_reg  <= wr_upper;
                rd_middle_reg <= wr_middle;
            end else begin
                rd_upper_reg  <= mem_upper[rd_addr];
                rd_middle_reg <= mem_middle[rd_addr];
            end
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

`default_nettype wire

[sv/lbp_window.sv]
// 3x3 window registers and the LBP code compare.
`timescale 1ns / 1ps
`default_nettype none

module lbp_window (
    input  wire logic                  aclk,
    input  wire logic                  shift_en,
    input  wire lbp_pkg::lbp_column_t  col_in,
    output lbp_pkg::pixel_t            code
);

    // col_a is the leftmost column after the shift, col_b the centre column
    lbp_pkg::lbp_column_t col_a_reg;
    lbp_pkg::lbp_column_t col_b_reg;
    lbp_pkg::pixel_t      centre;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_a_reg <= col_b_reg;
            col_b_reg <= col_in;
        end
    end

    assign centre = col_b_reg[1];

    // bit weights: 1 2 4 top row, 8 left, 16 right, 32 64 128 bottom row
    always_comb begin
        code[0] = (col_a_reg[0] >= centre);
        code[1] = (col_b_reg[0] >= centre);
        code[2] = (col_in[0]    >= centre);
        code[3] = (col_a_reg[1] >= centre);
        code[4] = (col_in[1]    >= centre);
        code[5] = (col_a_reg[2] >= centre);
        code[6] = (col_b_reg[2] >= centre);
        code[7] = (col_in[2]    >= centre);
    end

endmodule

`default_nettype wire

[sv/lbp_out_buf.sv]
// Output register holding up to two results of one pixel, code beat first.
`timescale 1ns / 1ps
`default_nettype none

module lbp_out_buf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire lbp_pkg::lbp_pair_t    pair_in,
    output logic                       load_ok,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lbp_pkg::lbp_result_t       m_data
);

    logic                 code_v_reg;
    logic                 code_v_next;
    logic                 bord_v_reg;
    logic                 bord_v_next;
    lbp_pkg::lbp_result_t code_res_reg;
    lbp_pkg::lbp_result_t bord_res_reg;
    logic                 m_fire;

    assign m_valid = code_v_reg || bord_v_reg;
    assign m_data  = code_v_reg ? code_res_reg : bord_res_reg;
    assign m_fire  = m_valid && m_ready;
    assign load_ok = (!code_v_reg && !bord_v_reg) || (m_ready && !(code_v_reg && bord_v_reg));

    always_comb begin
        code_v_next = code_v_reg && !m_fire;
        bord_v_next = bord_v_reg && !(m_fire && !code_v_reg);
        if (load) begin
            code_v_next = pair_in.code_valid;
            bord_v_next = pair_in.border_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_v_reg <= 1'b0;
            bord_v_reg <= 1'b0;
        end else begin
            code_v_reg <= code_v_next;
            bord_v_reg <= bord_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_res_reg <= pair_in.code_res;
            bord_res_reg <= pair_in.border_res;
        end
    end

endmodule

`default_nettype wire

[sv/lbp_3x3_operator.sv]
// Top level of the streaming 3x3 local binary pattern operator.
//
// Pixels enter on s_valid/s_ready/s_data in raster order, one per beat;
// frame_start on a beat restarts the position at row 0, column 0. Results
// leave on m_valid/m_ready/m_data: a border pixel copy in the beat order of
// its input, and the LBP code of an interior pixel once the pixel below and
// to its right arrives. A pixel causing both gives the code beat first, then
// the border beat; last_of_run marks the final beat of each pixel.
// Frame size is set through cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must do so only while the block is idle; the block itself does not enforce
// this. Zero counts as 1, larger values saturate to MAX_WIDTH and MAX_HEIGHT.
// An input beat is registered in stage 1, then in the output register, which
// drives its first result beat. Throughput: one pixel per cycle while m_ready is
// high, limited by the one-beat-per-cycle output register; a pixel with two
// results holds the output for both its beats. Reset clears position counters
// and sets both sizes to 1024; line stores need no clearing. When m_ready is
// low the output register and one stage behind it fill, then s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module lbp_3x3_operator #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire lbp_pkg::pixel_in_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output lbp_pkg::lbp_result_t                   m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int W_RST = (lbp_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : lbp_pkg::SIZE_RESET;
    localparam int H_RST = (lbp_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : lbp_pkg::SIZE_RESET;

    // frame size, stored already clamped
    logic [WW-1:0] w_reg;
    logic [WW-1:0] w_next;
    logic [HW-1:0] h_reg;
    logic [HW-1:0] h_next;
    logic [lbp_pkg::FRAME_WIDTH_W-1:0]  cfg_w_raw;
    logic [lbp_pkg::FRAME_HEIGHT_W-1:0] cfg_h_raw;
    logic [WW-1:0] cfg_w_clamped;
    logic [HW-1:0] cfg_h_clamped;

    // position of the next pixel
    logic [WW-1:0] col_pos_reg;
    logic [WW-1:0] col_pos_next;
    logic [HW-1:0] row_pos_reg;
    logic [HW-1:0] row_pos_next;
    logic [WW-1:0] col_cur;
    logic [HW-1:0] row_cur;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic [HW-1:0] row_wrap_inc;

    // stage 1
    logic            s_fire;
    logic            s1_adv;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    lbp_pkg::pixel_t pix1_reg;
    logic [WW-1:0]   col1_reg;
    logic [HW-1:0]   row1_reg;
    logic            code_flag_reg;
    logic            bord_flag_reg;
    logic            is_code;
    logic            is_bord;

    lbp_pkg::pixel_t      rd_upper;
    lbp_pkg::pixel_t      rd_middle;
    lbp_pkg::lbp_column_t win_col;
    lbp_pkg::pixel_t      lbp_code;
    lbp_pkg::lbp_pair_t   pair;
    logic                 load_ok;
    logic [WW-1:0]        col1_m1;
    logic [HW-1:0]        row1_m1;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_w_raw = cfg_data[lbp_pkg::FRAME_WIDTH_W-1:0];
    assign cfg_h_raw = cfg_data[lbp_pkg::FRAME_HEIGHT_W-1:0];

    always_comb begin
        if (cfg_w_raw == '0) begin
            cfg_w_clamped = WW'(1);
        end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
            cfg_w_clamped = WW'(MAX_WIDTH);
        end else begin
            cfg_w_clamped = WW'(cfg_w_raw);
        end
        if (cfg_h_raw == '0) begin
            cfg_h_clamped = HW'(1);
        end else if (32'(cfg_h_raw) > 32'(MAX_HEIGHT)) begin
            cfg_h_clamped = HW'(MAX_HEIGHT);
        end else begin
            cfg_h_clamped = HW'(cfg_h_raw);
        end
    end

    always_comb begin
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lbp_pkg::CFG_FRAME_WIDTH: begin
                    w_next = cfg_w_clamped;
                end
                lbp_pkg::CFG_FRAME_HEIGHT: begin
                    h_next = cfg_h_clamped;
                end
                default: begin
                    w_next = w_reg;
                end
            endcase
        end
    end

    // ---------------- position ----------------
    assign s_fire = s_valid && s_ready;

    always_comb begin
        col_cur      = col_pos_reg;
        row_cur      = row_pos_reg;
        row_wrap_inc = row_pos_reg + 1'b1;
        if (col_pos_reg >= w_reg) begin
            col_cur = '0;
            row_cur = row_wrap_inc;
        end
        if (row_cur >= h_reg) begin
            row_cur = '0;
        end
        if (s_data.frame_start) begin
            col_cur = '0;
            row_cur = '0;
        end
        col_inc = col_cur + 1'b1;
        row_inc = row_cur + 1'b1;
        if (col_inc >= w_reg) begin
            col_pos_next = '0;
            row_pos_next = (row_inc >= h_reg) ? '0 : row_inc;
        end else begin
            col_pos_next = col_inc;
            row_pos_next = row_cur;
        end
        is_code = (row_cur >= HW'(2)) && (col_cur >= WW'(2));
        is_bord = (row_cur == '0) || (row_inc == h_reg) || (col_cur == '0) || (col_inc == w_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg       <= WW'(W_RST);
            h_reg       <= HW'(H_RST);
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else begin
            w_reg <= w_next;
            h_reg <= h_next;
            if (s_fire) begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
        end
    end

    // ---------------- stage 1 ----------------
    assign s1_adv        = s1_valid_reg && load_ok;
    assign s_ready       = !s1_valid_reg || load_ok;
    assign s1_valid_next = s_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix1_reg      <= s_data.pixel_value;
            col1_reg      <= col_cur;
            row1_reg      <= row_cur;
            code_flag_reg <= is_code;
            bord_flag_reg <= is_bord;
        end
    end

    lbp_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .aclk      (aclk),
        .rd_en     (s_fire),
        .rd_addr   (col_cur[AW-1:0]),
        .wr_en     (s1_adv),
        .wr_addr   (col1_reg[AW-1:0]),
        .wr_upper  (rd_middle),
        .wr_middle (pix1_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    assign win_col = {pix1_reg, rd_middle, rd_upper};

    lbp_window u_window (
        .aclk     (aclk),
        .shift_en (s1_adv),
        .col_in   (win_col),
        .code     (lbp_code)
    );

    assign col1_m1 = col1_reg - 1'b1;
    assign row1_m1 = row1_reg - 1'b1;

    always_comb begin
        pair.code_valid             = code_flag_reg;
        pair.border_valid           = bord_flag_reg;
        pair.code_res.code_value    = lbp_code;
        pair.code_res.out_row       = lbp_pkg::out_row_t'(row1_m1);
        pair.code_res.out_column    = lbp_pkg::out_col_t'(col1_m1);
        pair.code_res.is_border     = 1'b0;
        pair.code_res.last_of_run   = !bord_flag_reg;
        pair.border_res.code_value  = pix1_reg;
        pair.border_res.out_row     = lbp_pkg::out_row_t'(row1_reg);
        pair.border_res.out_column  = lbp_pkg::out_col_t'(col1_reg);
        pair.border_res.is_border   = 1'b1;
        pair.border_res.last_of_run = 1'b1;
    end

    lbp_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s1_adv),
        .pair_in (pair),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[bench/lbp_result_checker.sv]
// Result checker for lbp_3x3_operator: watches all channels, predicts and compares result beats.
`timescale 1ns / 1ps

module lbp_result_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  lbp_pkg::pixel_in_t                s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  lbp_pkg::lbp_result_t              m_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                pending_count,
    output int                                beats_checked,
    output int                                codes_checked
);

    lbp_pkg::pixel_t                    upper_line [MAX_WIDTH];
    lbp_pkg::pixel_t                    middle_line [MAX_WIDTH];
    lbp_pkg::pixel_t                    win [3][3];
    int unsigned                        row_pos;
    int unsigned                        col_pos;
    logic [lbp_pkg::FRAME_WIDTH_W-1:0]  width_reg;
    logic [lbp_pkg::FRAME_HEIGHT_W-1:0] height_reg;
    lbp_pkg::lbp_result_t               expected_beats [$];
    int                                 mismatches;
    int                                 n_beats;
    int                                 n_codes;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic clear_state();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = lbp_pkg::FRAME_WIDTH_W'(lbp_pkg::SIZE_RESET);
        height_reg = lbp_pkg::FRAME_HEIGHT_W'(lbp_pkg::SIZE_RESET);
        expected_beats.delete();
        mismatches = 0;
        n_beats    = 0;
        n_codes    = 0;
    endtask

    task automatic take_pixel(input lbp_pkg::pixel_in_t px);
        int unsigned          w;
        int unsigned          h;
        int unsigned          r;
        int unsigned          c;
        lbp_pkg::pixel_t      centre;
        logic                 code_hit;
        logic                 border_hit;
        lbp_pkg::lbp_result_t beat;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        if (px.frame_start) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;

        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = px.pixel_value;
        upper_line[c]  = middle_line[c];
        middle_line[c] = px.pixel_value;

        code_hit   = (r >= 2) && (c >= 2);
        border_hit = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);

        if (code_hit) begin
            centre = win[1][1];
            beat.code_value  = {win[2][2] >= centre, win[2][1] >= centre, win[2][0] >= centre,
                                win[1][2] >= centre, win[1][0] >= centre,
                                win[0][2] >= centre, win[0][1] >= centre, win[0][0] >= centre};
            beat.out_row     = lbp_pkg::out_row_t'(r - 1);
            beat.out_column  = lbp_pkg::out_col_t'(c - 1);
            beat.is_border   = 1'b0;
            beat.last_of_run = !border_hit;
            expected_beats.push_back(beat);
        end
        if (border_hit) begin
            beat.code_value  = px.pixel_value;
            beat.out_row     = lbp_pkg::out_row_t'(r);
            beat.out_column  = lbp_pkg::out_col_t'(c);
            beat.is_border   = 1'b1;
            beat.last_of_run = 1'b1;
            expected_beats.push_back(beat);
        end

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic check_beat(input lbp_pkg::lbp_result_t got);
        lbp_pkg::lbp_result_t want;
        n_beats++;
        if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected beat code=%0d row=%0d col=%0d border=%0b last=%0b",
                         got.code_value, got.out_row, got.out_column, got.is_border,
                         got.last_of_run);
        end else begin
            want = expected_beats.pop_front();
            if (!want.is_border) n_codes++;
            if (got.code_value !== want.code_value || got.out_row !== want.out_row ||
                got.out_column !== want.out_column || got.is_border !== want.is_border ||
                got.last_of_run !== want.last_of_run) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: beat mismatch exp code=%0d row=%0d col=%0d ",
                              "border=%0b last=%0b, got code=%0d row=%0d col=%0d ",
                              "border=%0b last=%0b"},
                             want.code_value, want.out_row, want.out_column, want.is_border,
                             want.last_of_run, got.code_value, got.out_row, got.out_column,
                             got.is_border, got.last_of_run);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (lbp_pkg::cfg_index_t'(cfg_index))
                    lbp_pkg::CFG_FRAME_WIDTH:
                        width_reg  = cfg_data[lbp_pkg::FRAME_WIDTH_W-1:0];
                    lbp_pkg::CFG_FRAME_HEIGHT:
                        height_reg = cfg_data[lbp_pkg::FRAME_HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) take_pixel(s_data);
            if (m_valid && m_ready) check_beat(m_data);
        end
        fail_count    <= mismatches;
        pending_count <= expected_beats.size();
        beats_checked <= n_beats;
        codes_checked <= n_codes;
    end

endmodule

[bench/tb_lbp_3x3_operator.sv]
// Testbench top for lbp_3x3_operator: clock, reset, pixel and size stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_lbp_3x3_operator;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PIXELS = 800;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_RAND_W    = 12;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    lbp_pkg::pixel_in_t             s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    lbp_pkg::lbp_result_t           m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index = lbp_pkg::CFG_FRAME_WIDTH;
    logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending_count;
    int beats_checked;
    int codes_checked;

    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_sent    = 0;
    int size_settings  = 0;

    always #5 aclk = ~aclk;

    lbp_3x3_operator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lbp_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .beats_checked (beats_checked),
        .codes_checked (codes_checked)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, pending_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic lbp_pkg::pixel_t rand_pixel();
        case ($urandom_range(3))
            0:       return lbp_pkg::pixel_t'($urandom_range(255));
            1:       return lbp_pkg::pixel_t'(100 + $urandom_range(2));
            2:       return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return lbp_pkg::pixel_t'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input lbp_pkg::pixel_t pv, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid                <= 1'b1;
        s_data.pixel_value     <= pv;
        s_data.frame_start     <= fs;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // block goes quiet: all results back, plus margin for pixels that give none
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_size(input int w, input int h);
        cfg_valid <= 1'b1;
        cfg_index <= lbp_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= lbp_pkg::CFG_DATA_W'(w);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= lbp_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= lbp_pkg::CFG_DATA_W'(h);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // w and h are the effective sizes; noise_div > 0 adds random frame restarts
    task automatic send_frames(input int w, input int h, input int frames, input int noise_div);
        logic fs;
        for (int f = 0; f < frames; f++) begin
            for (int p = 0; p < w * h; p++) begin
                fs = (f == 0 && p == 0) || (p == 0 && $urandom_range(1) == 1) ||
                     (noise_div > 0 && $urandom_range(noise_div - 1) == 0);
                send_pixel(rand_pixel(), fs);
            end
        end
    endtask

    task automatic send_run(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel(), i == 0);
    endtask

    task automatic random_phase();
        int kind;
        int w;
        int h;
        int k;
        kind = $urandom_range(9);
        if (kind == 6) begin
            w = $urandom_range(0, 3);
            h = $urandom_range(0, 3);
        end else begin
            w = $urandom_range(4, MAX_RAND_W);
            h = $urandom_range(3, 8);
        end
        settle();
        set_frame_size(w, h);
        case (kind)
            6: send_frames((w == 0) ? 1 : w, (h == 0) ? 1 : h, 2, 0);
            7: begin
                // set a width no larger than before and a new height part way into a frame
                k = $urandom_range(w + 1, w * h - 1);
                send_run(k);
                settle();
                set_frame_size($urandom_range(0, w), $urandom_range(0, 10));
                k = $urandom_range(5, 40);
                for (int i = 0; i < k; i++)
                    send_pixel(rand_pixel(), 1'b0);
            end
            8: send_frames(w, h, 2, 8);
            9: send_frames(w, h, 3, 0);
            default: send_frames(w, h, $urandom_range(1, 2), 0);
        endcase
    endtask

    lbp_pkg::pixel_t directed_frame [20] = '{
        8'd0,   8'd255, 8'd128, 8'd128, 8'd0,
        8'd255, 8'd128, 8'd128, 8'd128, 8'd255,
        8'd128, 8'd0,   8'd128, 8'd255, 8'd128,
        8'd0,   8'd255, 8'd0,   8'd255, 8'd255
    };

    initial begin
        int start_count;
        set_idling(6, 85);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 5x4 frame with ties and extremes, wrap into next frame, then restart
        set_frame_size(5, 4);
        for (int i = 0; i < 20; i++)
            send_pixel(directed_frame[i], i == 0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd77, 1'b1);

        // two full rows at the widest random width so both line stores hold data there
        settle();
        set_frame_size(MAX_RAND_W, 2);
        send_frames(MAX_RAND_W, 2, 1, 0);

        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            if (pixels_sent - start_count < RANDOM_PIXELS / 3)
                set_idling(6, 85);
            else if (pixels_sent - start_count < 2 * RANDOM_PIXELS / 3)
                set_idling(85, 6);
            else
                set_idling(0, 0);
            random_phase();
        end

        // size extremes: zero, degenerate and out-of-range settings
        settle();
        set_frame_size(0, 0);
        send_run(3);
        settle();
        set_frame_size(2, 2);
        send_frames(2, 2, 2, 0);
        settle();
        set_frame_size(3, 3);
        send_frames(3, 3, 2, 0);
        settle();
        set_frame_size(2047, 8191);
        send_run(30);

        settle();
        $display("Summary: %0d pixels over %0d frame size settings, three idling modes",
                 pixels_sent, size_settings);
        $display("Summary: %0d result beats checked, %0d of them LBP codes",
                 beats_checked, codes_checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
sv/lbp_pkg.sv
sv/lbp_line_store.sv
sv/lbp_window.sv
sv/lbp_out_buf.sv
sv/lbp_3x3_operator.sv
bench/lbp_result_checker.sv
bench/tb_lbp_3x3_operator.sv
